// File: hw/rtl/drt_pkg.sv
package drt_pkg;

    // Table geometry
    localparam int MAX_RECTS = 32;
    localparam int IDX_W     = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CNT_W     = $clog2(MAX_RECTS + 1);

    // Field widths
    localparam int COORD_W   = 16;
    localparam int SIZE_W    = 17;
    localparam int IN_SIZE_W = 16;
    localparam int OP_W      = 3;
    localparam int EIDX_W    = 6;
    localparam int ECNT_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    // Opcodes
    localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
    localparam logic [OP_W-1:0] OP_MARK_FULL = 3'd1;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd2;
    localparam logic [OP_W-1:0] OP_READ      = 3'd3;
    localparam logic [OP_W-1:0] OP_BOUNDS    = 3'd4;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

    typedef struct packed {
        logic [OP_W-1:0]           opcode;
        logic signed [COORD_W-1:0] rect_x;
        logic signed [COORD_W-1:0] rect_y;
        logic [IN_SIZE_W-1:0]      rect_width;
        logic [IN_SIZE_W-1:0]      rect_height;
        logic [EIDX_W-1:0]         entry_index;
    } item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic [SIZE_W-1:0]         out_width;
        logic [SIZE_W-1:0]         out_height;
        logic [ECNT_W-1:0]         entry_count;
        logic                      full_flag;
        logic                      empty_flag;
    } result_t;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_IDX,
        RD_NEXT
    } rd_sel_t;

    typedef enum logic [1:0] {
        RES_SCREEN,
        RES_ENTRY,
        RES_ACC
    } res_sel_t;

    typedef struct packed {
        logic     load_item;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     ptr_clr;
        logic     ptr_inc;
        logic     wr_merge;
        logic     append;
        logic     set_full;
        logic     clear;
        logic     res_load;
        res_sel_t res_sel;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            add_null;
        logic            full;
        logic            count_zero;
        logic            idx_valid;
        logic            overlap;
        logic            last;
        logic            table_full;
        logic            out_free;
    } dp_status_t;

endpackage

// File: hw/rtl/drt_ctrl.sv
module drt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  drt_pkg::dp_status_t st,
    output drt_pkg::dp_cmd_t    cmd
);
    import drt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_RDWAIT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   stall_reg;

    assign item_stall = stall_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_DONE;
                case (st.op)
                    OP_ADD:
                    begin
                        if (!(st.add_null || st.full))
                        begin
                            if (st.count_zero)
                                cmd.append = 1'b1;
                            else
                            begin
                                cmd.rd_en   = 1'b1;
                                cmd.rd_sel  = RD_ZERO;
                                cmd.ptr_clr = 1'b1;
                                state_next  = S_SCAN;
                            end
                        end
                    end
                    OP_MARK_FULL: cmd.set_full = 1'b1;
                    OP_CLEAR:     cmd.clear = 1'b1;
                    OP_READ:
                    begin
                        if (st.idx_valid)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = RD_IDX;
                            state_next = S_RDWAIT;
                        end
                    end
                    OP_BOUNDS:
                    begin
                        if (st.full)
                        begin
                            cmd.res_load = 1'b1;
                            cmd.res_sel  = RES_SCREEN;
                        end
                        else if (!st.count_zero)
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_sel  = RD_ZERO;
                            cmd.ptr_clr = 1'b1;
                            state_next  = S_SCAN;
                        end
                    end
                    default: ;
                endcase
            end
            S_SCAN:
            begin
                if (st.op == OP_ADD)
                begin
                    if (st.overlap)
                    begin
                        cmd.wr_merge = 1'b1;
                        state_next   = S_DONE;
                    end
                    else if (st.last)
                    begin
                        if (st.table_full)
                            cmd.set_full = 1'b1;
                        else
                            cmd.append = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.ptr_inc = 1'b1;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RD_NEXT;
                    end
                end
                else
                begin
                    if (st.last)
                    begin
                        cmd.res_load = 1'b1;
                        cmd.res_sel  = RES_ACC;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        cmd.ptr_inc = 1'b1;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RD_NEXT;
                    end
                end
            end
            S_RDWAIT:
            begin
                cmd.res_load = 1'b1;
                cmd.res_sel  = RES_ENTRY;
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= (state_next != S_IDLE);
        end
    end

endmodule

// File: hw/rtl/drt_datapath.sv
module drt_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  drt_pkg::item_t      item,
    input  logic                cfg_wr_en,
    input  logic [drt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [drt_pkg::CFG_W-1:0]     cfg_data,
    input  drt_pkg::dp_cmd_t    cmd,
    output drt_pkg::dp_status_t st,
    output logic                result_valid,
    input  logic                result_stall,
    output drt_pkg::result_t    result
);
    import drt_pkg::*;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
    } box_t;

    localparam int EXT_W = COORD_W + 2;

    function automatic logic signed [EXT_W-1:0] sext(logic signed [COORD_W-1:0] v);
        return $signed({{2{v[COORD_W-1]}}, v});
    endfunction

    function automatic logic signed [EXT_W-1:0] far_edge(logic signed [COORD_W-1:0] v,
                                                        logic [SIZE_W-1:0] s);
        return sext(v) + $signed({1'b0, s});
    endfunction

    // strict overlap: touching edges do not count
    function automatic logic rect_overlap(box_t a, box_t b);
        logic signed [EXT_W-1:0] ax1, ay1, bx1, by1;
        ax1 = far_edge(a.x, a.w);
        ay1 = far_edge(a.y, a.h);
        bx1 = far_edge(b.x, b.w);
        by1 = far_edge(b.y, b.h);
        return !(ax1 <= sext(b.x) || bx1 <= sext(a.x) ||
                 ay1 <= sext(b.y) || by1 <= sext(a.y));
    endfunction

    function automatic box_t box_hull(box_t a, box_t b);
        logic signed [EXT_W-1:0] ax1, ay1, bx1, by1, x1, y1, dx, dy;
        box_t r;
        ax1 = far_edge(a.x, a.w);
        ay1 = far_edge(a.y, a.h);
        bx1 = far_edge(b.x, b.w);
        by1 = far_edge(b.y, b.h);
        x1  = (ax1 > bx1) ? ax1 : bx1;
        y1  = (ay1 > by1) ? ay1 : by1;
        r.x = (a.x < b.x) ? a.x : b.x;
        r.y = (a.y < b.y) ? a.y : b.y;
        dx  = x1 - sext(r.x);
        dy  = y1 - sext(r.y);
        r.w = dx[SIZE_W-1:0];
        r.h = dy[SIZE_W-1:0];
        return r;
    endfunction

    item_t               item_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                full_reg;
    logic [IDX_W-1:0]    ptr_reg;
    box_t                acc_reg;
    box_t                res_reg;
    logic [CFG_W-1:0]    scr_w_reg;
    logic [CFG_W-1:0]    scr_h_reg;
    logic                out_valid_reg;
    result_t             out_reg;

    box_t                mem [MAX_RECTS];
    box_t                mem_q;

    box_t                nb;
    box_t                acc_in;
    box_t                wr_data;
    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    wr_addr;
    logic                wr_en;
    logic [CNT_W:0]      ptr_plus1;

    always_comb
    begin
        nb.x = item_reg.rect_x;
        nb.y = item_reg.rect_y;
        nb.w = {1'b0, item_reg.rect_width};
        nb.h = {1'b0, item_reg.rect_height};
    end

    assign ptr_plus1 = (CNT_W + 1)'(ptr_reg) + 1'b1;
    assign acc_in    = (ptr_reg == '0) ? mem_q : box_hull(acc_reg, mem_q);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_IDX:  rd_addr = item_reg.entry_index[IDX_W-1:0];
            RD_NEXT: rd_addr = ptr_plus1[IDX_W-1:0];
            default: rd_addr = '0;
        endcase
    end

    assign wr_en   = cmd.wr_merge | cmd.append;
    assign wr_addr = cmd.wr_merge ? ptr_reg : count_reg[IDX_W-1:0];
    assign wr_data = cmd.wr_merge ? box_hull(mem_q, nb) : nb;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.rd_en)
            mem_q <= mem[rd_addr];
    end

    always_comb
    begin
        st.op         = item_reg.opcode;
        st.add_null   = (item_reg.rect_width == '0) || (item_reg.rect_height == '0);
        st.full       = full_reg;
        st.count_zero = (count_reg == '0);
        st.idx_valid  = ({1'b0, item_reg.entry_index} < ECNT_W'(count_reg));
        st.overlap    = rect_overlap(mem_q, nb);
        st.last       = (ptr_plus1 == (CNT_W + 1)'(count_reg));
        st.table_full = (count_reg == CNT_W'(MAX_RECTS));
        st.out_free   = !out_valid_reg || !result_stall;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            full_reg      <= 1'b0;
            scr_w_reg     <= '0;
            scr_h_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
                full_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.append)
                    count_reg <= count_reg + 1'b1;
                if (cmd.set_full)
                    full_reg <= 1'b1;
            end

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_SCREEN_WIDTH:  scr_w_reg <= cfg_data;
                    REG_SCREEN_HEIGHT: scr_h_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
            item_reg <= item;

        if (cmd.ptr_clr)
            ptr_reg <= '0;
        else if (cmd.ptr_inc)
            ptr_reg <= ptr_plus1[IDX_W-1:0];

        if (cmd.ptr_inc)
            acc_reg <= acc_in;

        if (cmd.load_item)
            res_reg <= '0;
        else if (cmd.res_load)
        begin
            case (cmd.res_sel)
                RES_SCREEN:
                begin
                    res_reg.x <= '0;
                    res_reg.y <= '0;
                    res_reg.w <= {1'b0, scr_w_reg};
                    res_reg.h <= {1'b0, scr_h_reg};
                end
                RES_ENTRY: res_reg <= mem_q;
                RES_ACC:   res_reg <= acc_in;
                default:   res_reg <= '0;
            endcase
        end

        if (cmd.out_load)
        begin
            out_reg.out_x       <= res_reg.x;
            out_reg.out_y       <= res_reg.y;
            out_reg.out_width   <= res_reg.w;
            out_reg.out_height  <= res_reg.h;
            out_reg.entry_count <= ECNT_W'(count_reg);
            out_reg.full_flag   <= full_reg;
            out_reg.empty_flag  <= (count_reg == '0) && !full_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RECTS))
        else $error("entry count beyond table depth");

    a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.append |-> (count_reg < CNT_W'(MAX_RECTS)))
        else $error("append into a full table");

    a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.wr_merge && cmd.append))
        else $error("merge and append in the same cycle");

    a_clear_effect: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |=> (count_reg == '0) && !full_reg)
        else $error("clear left table state behind");

endmodule

// File: hw/rtl/damage_rect_tracker_core.sv
// Damage rectangle tracker.
// Input channel (item_valid / item_stall / item) takes one command per transfer:
// add rectangle, mark full, clear, read entry or report bounds. Every command
// yields exactly one transfer on the result channel (result_valid /
// result_stall / result) carrying the rectangle read or the bounds (zero for
// other commands) and the entry count, full and empty flags after the command.
// Mark full, clear, rejected adds, reads beyond the count and unknown codes go
// from decode straight to the done state; a valid read entry first passes the
// read wait state; add and bounds scan table entries (one per cycle, up to 32)
// through the single registered read port of the table memory.
// A new command is taken in the cycle after the previous result is loaded into
// the output register, when the block is back in idle.
// Screen size registers are written through cfg_wr_en / cfg_index / cfg_data; the
// user must write them only while the block is idle, the block does not enforce it.
// Reset clears the entry count, the full flag, the screen size and the output
// valid; table contents are not cleared. While the receiver stalls, the result
// register holds; the next command is still taken and worked on, and waits for
// the output register before its result is loaded.
module damage_rect_tracker_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_stall,
    input  drt_pkg::item_t                item,
    output logic                          result_valid,
    input  logic                          result_stall,
    output drt_pkg::result_t              result,
    input  logic                          cfg_wr_en,
    input  logic [drt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [drt_pkg::CFG_W-1:0]     cfg_data
);
    import drt_pkg::*;

    // command and status between sequencer and datapath
    dp_cmd_t    cmd;
    dp_status_t st;

    drt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .st         (st),
        .cmd        (cmd)
    );

    // table memory, scan pointer, accumulator and output register
    drt_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .st           (st),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

// File: test/rect_table_checker.sv
module rect_table_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic                          item_stall,
    input  drt_pkg::item_t                item,
    input  logic                          result_valid,
    input  logic                          result_stall,
    input  drt_pkg::result_t              result,
    input  logic                          cfg_wr_en,
    input  logic [drt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [drt_pkg::CFG_W-1:0]     cfg_data,
    output int                            failures,
    output int                            outstanding
);
    import drt_pkg::*;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
    } rect_t;

    rect_t            damage_list [MAX_RECTS];
    int               held;
    bit               screen_full;
    logic [CFG_W-1:0] screen_w;
    logic [CFG_W-1:0] screen_h;
    result_t          awaited [$];
    result_t          want;

    // strict overlap: shared edges do not count
    function automatic bit boxes_cross(rect_t a, rect_t b);
        int ax1, ay1, bx1, by1;
        ax1 = int'(a.x) + int'(a.w);
        ay1 = int'(a.y) + int'(a.h);
        bx1 = int'(b.x) + int'(b.w);
        by1 = int'(b.y) + int'(b.h);
        return !(ax1 <= int'(b.x) || bx1 <= int'(a.x) ||
                 ay1 <= int'(b.y) || by1 <= int'(a.y));
    endfunction

    function automatic rect_t hull_of(rect_t a, rect_t b);
        rect_t u;
        int    x1, y1;
        x1 = int'(a.x) + int'(a.w);
        y1 = int'(a.y) + int'(a.h);
        if (int'(b.x) + int'(b.w) > x1) x1 = int'(b.x) + int'(b.w);
        if (int'(b.y) + int'(b.h) > y1) y1 = int'(b.y) + int'(b.h);
        u.x = (a.x < b.x) ? a.x : b.x;
        u.y = (a.y < b.y) ? a.y : b.y;
        u.w = SIZE_W'(x1 - int'(u.x));
        u.h = SIZE_W'(y1 - int'(u.y));
        return u;
    endfunction

    // updates the table copy and returns the result the command should give
    function automatic result_t apply_command(item_t it);
        result_t r;
        rect_t   nb, acc;
        bit      merged;
        r      = '0;
        acc    = '0;
        merged = 1'b0;
        case (it.opcode)
            OP_ADD:
            begin
                nb.x = it.rect_x;
                nb.y = it.rect_y;
                nb.w = {1'b0, it.rect_width};
                nb.h = {1'b0, it.rect_height};
                if (it.rect_width != 0 && it.rect_height != 0 && !screen_full)
                begin
                    for (int i = 0; i < held; i++)
                    begin
                        if (!merged && boxes_cross(damage_list[i], nb))
                        begin
                            damage_list[i] = hull_of(damage_list[i], nb);
                            merged = 1'b1;
                        end
                    end
                    if (!merged)
                    begin
                        if (held < MAX_RECTS)
                        begin
                            damage_list[held] = nb;
                            held++;
                        end
                        else
                        begin
                            screen_full = 1'b1;
                        end
                    end
                end
            end
            OP_MARK_FULL: screen_full = 1'b1;
            OP_CLEAR:
            begin
                held        = 0;
                screen_full = 1'b0;
            end
            OP_READ:
            begin
                if (int'(it.entry_index) < held)
                    acc = damage_list[it.entry_index[IDX_W-1:0]];
            end
            OP_BOUNDS:
            begin
                if (screen_full)
                begin
                    acc.w = {1'b0, screen_w};
                    acc.h = {1'b0, screen_h};
                end
                else if (held > 0)
                begin
                    acc = damage_list[0];
                    for (int i = 1; i < held; i++) acc = hull_of(acc, damage_list[i]);
                end
            end
            default: ;
        endcase
        r.out_x       = acc.x;
        r.out_y       = acc.y;
        r.out_width   = acc.w;
        r.out_height  = acc.h;
        r.entry_count = ECNT_W'(held);
        r.full_flag   = screen_full;
        r.empty_flag  = (held == 0) && !screen_full;
        return r;
    endfunction

    task automatic check_field(string name, int exp_v, int got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held        = 0;
            screen_full = 1'b0;
            screen_w    = '0;
            screen_h    = '0;
            awaited.delete();
            failures    = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_SCREEN_WIDTH:  screen_w = cfg_data;
                    REG_SCREEN_HEIGHT: screen_h = cfg_data;
                    default: ;
                endcase
            end
            if (result_valid && !result_stall)
            begin
                if (awaited.size() == 0)
                begin
                    $error("result transfer with no command outstanding");
                    failures++;
                end
                else
                begin
                    want = awaited.pop_front();
                    check_field("out_x", want.out_x, result.out_x);
                    check_field("out_y", want.out_y, result.out_y);
                    check_field("out_width", want.out_width, result.out_width);
                    check_field("out_height", want.out_height, result.out_height);
                    check_field("entry_count", want.entry_count, result.entry_count);
                    check_field("full_flag", want.full_flag, result.full_flag);
                    check_field("empty_flag", want.empty_flag, result.empty_flag);
                end
            end
            if (item_valid && !item_stall) awaited.push_back(apply_command(item));
            outstanding = awaited.size();
        end
    end

endmodule

// File: test/testbench.sv
module testbench;
    import drt_pkg::*;

    // how add rectangles are placed in the random part
    typedef enum {
        SPREAD_WIDE,     // any coordinate, any size
        SPREAD_CLUSTER,  // small rectangles around one point: many merges
        SPREAD_GRID      // side by side, never overlapping: fills the table
    } spread_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_stall;
    item_t                item         = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result;
    logic                 cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = REG_SCREEN_WIDTH;
    logic [CFG_W-1:0]     cfg_data     = '0;

    int failures;
    int outstanding;
    bit calm = 1'b0;    // no idling on either side while set
    int sent = 0;
    int grid_x, grid_y, slot;
    int clus_x, clus_y;

    always #5 clk = ~clk;

    // receiver back-pressure, changed on the falling edge only
    always @(negedge clk) result_stall <= !calm && ($urandom_range(99) < 24);

    damage_rect_tracker_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    rect_table_checker rect_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .failures     (failures),
        .outstanding  (outstanding)
    );

    function automatic item_t make_item(logic [OP_W-1:0] op, int x, int y, int w, int h,
                                        int idx);
        item_t it;
        it.opcode      = op;
        it.rect_x      = x[COORD_W-1:0];
        it.rect_y      = y[COORD_W-1:0];
        it.rect_width  = w[IN_SIZE_W-1:0];
        it.rect_height = h[IN_SIZE_W-1:0];
        it.entry_index = idx[EIDX_W-1:0];
        return it;
    endfunction

    // mostly adds; mark full kept rare so the table gets a chance to fill
    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 55) return OP_ADD;
        if (r < 57) return OP_MARK_FULL;
        if (r < 63) return OP_CLEAR;
        if (r < 80) return OP_READ;
        if (r < 96) return OP_BOUNDS;
        return OP_BOUNDS + OP_W'($urandom_range(1, 3));   // undefined codes
    endfunction

    function automatic item_t random_item(spread_t spread);
        logic [OP_W-1:0] op;
        int              x, y, w, h, idx, r;
        r   = $urandom_range(99);
        idx = ($urandom_range(99) < 80) ? $urandom_range(0, 34) : $urandom_range(0, 63);
        case (spread)
            SPREAD_GRID:
            begin
                op = (r < 75) ? OP_ADD : (r < 90) ? OP_READ : OP_BOUNDS;
                // slot pitch of 70 with widths up to 70: neighbours touch at most
                x = grid_x + slot * 70;
                y = grid_y + $urandom_range(0, 50);
                w = $urandom_range(1, 70);
                h = $urandom_range(1, 200);
                if (op == OP_ADD) slot++;
            end
            SPREAD_CLUSTER:
            begin
                op = pick_op();
                x  = clus_x + $urandom_range(0, 400) - 200;
                y  = clus_y + $urandom_range(0, 400) - 200;
                w  = (r < 2) ? 0 : $urandom_range(1, 60);
                h  = (r >= 2 && r < 4) ? 0 : $urandom_range(1, 60);
            end
            default:
            begin
                op = pick_op();
                x  = $urandom;
                y  = $urandom;
                w  = (r < 3) ? 0 : $urandom;
                h  = (r >= 3 && r < 6) ? 0 : $urandom;
            end
        endcase
        return make_item(op, x, y, w, h, idx);
    endfunction

    // one transfer on the command channel, with a random gap in front
    task automatic send(item_t it);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 24)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item       = it;
        item_valid = 1'b1;
        do @(posedge clk); while (item_stall);
        sent++;
    endtask

    // hold off until every result has been taken
    task automatic settle();
        @(negedge clk);
        item_valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic write_screen(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_index = REG_SCREEN_WIDTH;
        cfg_data  = w;
        @(negedge clk);
        cfg_index = REG_SCREEN_HEIGHT;
        cfg_data  = h;
        @(negedge clk);
        cfg_wr_en = 1'b0;
    endtask

    initial
    begin
        int phase, n, r;
        phase = 0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        write_screen(16'hFFFF, 16'hFFFF);

        // directed: empty table, null adds, coordinate extremes, merges
        send(make_item(OP_BOUNDS, 0, 0, 0, 0, 0));
        send(make_item(OP_READ, 0, 0, 0, 0, 0));
        send(make_item(OP_ADD, 10, 10, 0, 5, 0));
        send(make_item(OP_ADD, 10, 10, 5, 0, 0));
        send(make_item(OP_ADD, -32768, -32768, 65535, 65535, 0));
        // starts exactly on the far edge of the first: no overlap, appended
        send(make_item(OP_ADD, 32767, 32767, 65535, 65535, 0));
        send(make_item(OP_ADD, 0, 0, 1, 1, 0));
        send(make_item(OP_ADD, 32767, -32768, 1, 1, 0));
        // overlaps first and second, only the first one grows
        send(make_item(OP_ADD, -100, 32000, 40000, 5000, 0));
        send(make_item(OP_READ, 0, 0, 0, 0, 0));
        send(make_item(OP_READ, 0, 0, 0, 0, 1));
        send(make_item(OP_READ, 0, 0, 0, 0, 2));
        send(make_item(OP_READ, 0, 0, 0, 0, 3));
        send(make_item(OP_READ, 0, 0, 0, 0, 63));
        send(make_item(OP_BOUNDS, 0, 0, 0, 0, 0));
        send(make_item(OP_BOUNDS + 3'd1, 1, 1, 1, 1, 1));
        send(make_item(OP_BOUNDS + 3'd2, 1, 1, 1, 1, 1));
        send(make_item(OP_BOUNDS + 3'd3, -1, -1, 65535, 65535, 63));
        send(make_item(OP_MARK_FULL, 0, 0, 0, 0, 0));
        send(make_item(OP_ADD, 5000, 5000, 10, 10, 0));
        send(make_item(OP_BOUNDS, 0, 0, 0, 0, 0));
        send(make_item(OP_READ, 0, 0, 0, 0, 1));
        send(make_item(OP_CLEAR, 0, 0, 0, 0, 0));
        send(make_item(OP_BOUNDS, 0, 0, 0, 0, 0));
        send(make_item(OP_ADD, 3, 4, 5, 6, 0));

        // random bursts; screen size changes between phases
        while (sent < 1700)
        begin
            if (sent >= 450 * (phase + 1))
            begin
                settle();
                case (phase)
                    0:       write_screen(16'h0000, 16'h0000);
                    1:       write_screen(16'h0001, 16'hFFFF);
                    2:       write_screen(CFG_W'($urandom), CFG_W'($urandom));
                    default: write_screen(16'hFFFF, 16'h0001);
                endcase
                phase++;
            end
            calm = (sent >= 900 && sent < 1100);
            r    = $urandom_range(99);
            if (r < 25)
            begin
                // clear, fill towards overflow, then ask for the bounds
                grid_x = $urandom_range(0, 40000) - 20000;
                grid_y = $urandom_range(0, 60000) - 30000;
                slot   = 0;
                n      = $urandom_range(30, 55);
                send(make_item(OP_CLEAR, 0, 0, 0, 0, 0));
                repeat (n) send(random_item(SPREAD_GRID));
                send(make_item(OP_BOUNDS, 0, 0, 0, 0, 0));
            end
            else if (r < 75)
            begin
                clus_x = $urandom_range(0, 65535) - 32768;
                clus_y = $urandom_range(0, 65535) - 32768;
                repeat (30) send(random_item(SPREAD_CLUSTER));
            end
            else
            begin
                repeat (30) send(random_item(SPREAD_WIDE));
            end
        end

        settle();
        repeat (40) @(posedge clk);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial
    begin
        #15_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/drt_pkg.sv
hw/rtl/drt_ctrl.sv
hw/rtl/drt_datapath.sv
hw/rtl/damage_rect_tracker_core.sv
test/rect_table_checker.sv
test/testbench.sv
